FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the lift position step RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define DLPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dlps assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define DLPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dlps assertion failed");
`else
`define DLPS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define DLPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/dlps_pkg.sv
// Shared constants and register index codes for the lift position step block.
package dlps_pkg;

    // Default coordinate width in bits; coordinates are in micrometres.
    localparam int COORD_BITS_DEFAULT = 24;

    // Gain is unsigned Q8.8, deadband fraction is unsigned Q0.16.
    localparam int GAIN_BITS = 16;
    localparam int GAIN_FRAC = 8;
    localparam int FRAC_BITS = 16;

    // Configuration register indexes.
    localparam int CFG_ADDR_BITS = 3;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_REST_X            = 3'd0,
        REG_REST_Y            = 3'd1,
        REG_REST_Z            = 3'd2,
        REG_STEP_GAIN         = 3'd3,
        REG_DEADBAND_FRACTION = 3'd4,
        REG_HEIGHT_MAX        = 3'd5,
        REG_HEIGHT_MIN        = 3'd6
    } cfg_index_t;

    // Reset values of the configuration registers that do not reset to zero.
    localparam logic [GAIN_BITS-1:0] STEP_GAIN_RESET         = 16'd256;
    localparam logic [FRAC_BITS-1:0] DEADBAND_FRACTION_RESET = 16'd3277;
    localparam logic [31:0]          HEIGHT_MAX_RESET        = 32'd500000;

endpackage

FILE: rtl/core/dlps_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per item and passes it on.
`include "assert_macros.svh"

module dlps_sqrt_cell #(
    parameter int RT_BITS = 25,
    parameter int SIDE_W  = 27
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [2*RT_BITS-1:0] in_rad,
    input  logic [RT_BITS+1:0]   in_rem,
    input  logic [RT_BITS-1:0]   in_root,
    input  logic [SIDE_W-1:0]    in_side,
    output logic                 out_valid,
    output logic [2*RT_BITS-1:0] out_rad,
    output logic [RT_BITS+1:0]   out_rem,
    output logic [RT_BITS-1:0]   out_root,
    output logic [SIDE_W-1:0]    out_side
);

    localparam int SQ_BITS = 2 * RT_BITS;
    localparam int REM_W   = RT_BITS + 2;

    logic                 out_valid_reg;
    logic [SQ_BITS-1:0]   out_rad_reg;
    logic [REM_W-1:0]     out_rem_reg;
    logic [RT_BITS-1:0]   out_root_reg;
    logic [SIDE_W-1:0]    out_side_reg;

    logic [REM_W-1:0]     cand;
    logic [REM_W-1:0]     trial;
    logic                 fits;
    logic [SQ_BITS-1:0]   rad_next;
    logic [REM_W-1:0]     rem_next;
    logic [RT_BITS-1:0]   root_next;

    // Bring down the next two radicand bits and try the root bit at this position.
    always_comb
    begin
        cand      = {in_rem[RT_BITS-1:0], in_rad[SQ_BITS-1 -: 2]};
        trial     = {in_root, 2'b01};
        fits      = (cand >= trial);
        rem_next  = fits ? (cand - trial) : cand;
        root_next = {in_root[RT_BITS-2:0], fits};
        rad_next  = {in_rad[SQ_BITS-3:0], 2'b00};
    end

    // Item valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= in_valid;
        end
    end

    // Item payload moves on every cycle.
    always_ff @(posedge clk)
    begin
        out_rad_reg  <= rad_next;
        out_rem_reg  <= rem_next;
        out_root_reg <= root_next;
        out_side_reg <= in_side;
    end

    assign out_valid = out_valid_reg;
    assign out_rad   = out_rad_reg;
    assign out_rem   = out_rem_reg;
    assign out_root  = out_root_reg;
    assign out_side  = out_side_reg;

    // The partial remainder never exceeds twice the partial root.
    `DLPS_ASSERT_NOW(a_rem_bound, clk, rst_n, out_valid_reg, out_rem_reg <= {1'b0, out_root_reg, 1'b0})

endmodule

FILE: rtl/core/deflection_driven_lift_position_step.sv
// Top level of the deflection driven lift position step pipeline.
//
// Usage: drive wrist_x, wrist_y, wrist_z and current_height and raise start for
// one cycle; the item is taken at that clock edge. busy is always low, so a new
// item may be started in every cycle and several items travel the pipeline at once.
// Each item yields one target_height, shown for exactly one cycle with done high.
// Throughput is one item per cycle. The pipeline holds difference, square and sum
// stages, the square root chain of COORD_BITS + 1 cells, one cell per root bit,
// and the gain multiply and output stages.
// The receiver cannot stall the block; results leave in the order items entered.
// Configuration: cfg_we, cfg_addr and cfg_wdata write one register per edge,
// to be used only while no item is in flight. Unknown indexes are ignored.
// Reset clears the pipeline valid flags and loads the register defaults; items
// in flight at reset are dropped.
`include "assert_macros.svh"

module deflection_driven_lift_position_step
    import dlps_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [COORD_BITS-1:0]    wrist_x,
    input  logic [COORD_BITS-1:0]    wrist_y,
    input  logic [COORD_BITS-1:0]    wrist_z,
    input  logic [COORD_BITS-1:0]    current_height,
    output logic                     done,
    output logic [COORD_BITS-1:0]    target_height,
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [COORD_BITS-1:0]    cfg_wdata
);

    localparam int C       = COORD_BITS;
    localparam int RT_BITS = C + 1;
    localparam int SQ_BITS = 2 * C + 2;
    localparam int REM_W   = RT_BITS + 2;
    localparam int SIDE_W  = C + 3;
    localparam int BAND_W  = C + FRAC_BITS + 2;
    localparam int PROD_W  = RT_BITS + GAIN_BITS;
    localparam int MAG_W   = PROD_W - GAIN_FRAC;
    localparam int SUM_W   = C + 11;
    localparam int LAT     = RT_BITS + 5;

    // Configuration registers.
    logic [C-1:0]         rest_x_reg;
    logic [C-1:0]         rest_y_reg;
    logic [C-1:0]         rest_z_reg;
    logic [GAIN_BITS-1:0] step_gain_reg;
    logic [FRAC_BITS-1:0] deadband_reg;
    logic [C-1:0]         height_max_reg;
    logic [C-1:0]         height_min_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_x_reg     <= '0;
            rest_y_reg     <= '0;
            rest_z_reg     <= '0;
            step_gain_reg  <= STEP_GAIN_RESET;
            deadband_reg   <= DEADBAND_FRACTION_RESET;
            height_max_reg <= HEIGHT_MAX_RESET[C-1:0];
            height_min_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_REST_X:            rest_x_reg     <= cfg_wdata;
                REG_REST_Y:            rest_y_reg     <= cfg_wdata;
                REG_REST_Z:            rest_z_reg     <= cfg_wdata;
                REG_STEP_GAIN:         step_gain_reg  <= cfg_wdata[GAIN_BITS-1:0];
                REG_DEADBAND_FRACTION: deadband_reg   <= cfg_wdata[FRAC_BITS-1:0];
                REG_HEIGHT_MAX:        height_max_reg <= cfg_wdata;
                REG_HEIGHT_MIN:        height_min_reg <= cfg_wdata;
                default:               ;
            endcase
        end
    end

    // The pipeline takes an item in every cycle.
    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Stage A: absolute differences from the rest point and the band bounds.
    logic [C:0]              dx_full, dy_full, dz_full;
    logic [C:0]              dx_neg, dy_neg, dz_neg;
    logic [FRAC_BITS:0]      hi_mult, lo_mult;
    logic                    a_valid_reg;
    logic [C-1:0]            a_ax_reg, a_ay_reg, a_az_reg;
    logic [C-1:0]            a_wx_reg;
    logic [C-1:0]            a_cur_reg;
    logic                    a_neg_reg;
    logic signed [BAND_W-1:0] a_band_hi_reg, a_band_lo_reg;

    always_comb
    begin
        dx_full = {wrist_x[C-1], wrist_x} - {rest_x_reg[C-1], rest_x_reg};
        dy_full = {wrist_y[C-1], wrist_y} - {rest_y_reg[C-1], rest_y_reg};
        dz_full = {wrist_z[C-1], wrist_z} - {rest_z_reg[C-1], rest_z_reg};
        dx_neg  = -dx_full;
        dy_neg  = -dy_full;
        dz_neg  = -dz_full;
        hi_mult = {1'b1, deadband_reg};
        lo_mult = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, deadband_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        a_ax_reg      <= dx_full[C] ? dx_neg[C-1:0] : dx_full[C-1:0];
        a_ay_reg      <= dy_full[C] ? dy_neg[C-1:0] : dy_full[C-1:0];
        a_az_reg      <= dz_full[C] ? dz_neg[C-1:0] : dz_full[C-1:0];
        a_wx_reg      <= wrist_x;
        a_cur_reg     <= current_height;
        a_neg_reg     <= dx_full[C];
        a_band_hi_reg <= BAND_W'($signed(rest_x_reg)) * BAND_W'($signed({1'b0, hi_mult}));
        a_band_lo_reg <= BAND_W'($signed(rest_x_reg)) * BAND_W'($signed({1'b0, lo_mult}));
    end

    // Stage B: squares and the band tests, the upper test taking priority later.
    logic signed [BAND_W-1:0] xs;
    logic                     b_valid_reg;
    logic [2*C-1:0]           b_sqx_reg, b_sqy_reg, b_sqz_reg;
    logic                     b_neg_reg, b_above_reg, b_below_reg;
    logic [C-1:0]             b_cur_reg;

    assign xs = $signed({{2{a_wx_reg[C-1]}}, a_wx_reg, {FRAC_BITS{1'b0}}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_sqx_reg   <= (2*C)'(a_ax_reg) * (2*C)'(a_ax_reg);
        b_sqy_reg   <= (2*C)'(a_ay_reg) * (2*C)'(a_ay_reg);
        b_sqz_reg   <= (2*C)'(a_az_reg) * (2*C)'(a_az_reg);
        b_neg_reg   <= a_neg_reg;
        b_above_reg <= (xs > a_band_hi_reg);
        b_below_reg <= (xs < a_band_lo_reg);
        b_cur_reg   <= a_cur_reg;
    end

    // Stage C: sum of squares, the radicand of the root chain.
    logic               c_valid_reg;
    logic [SQ_BITS-1:0] c_rad_reg;
    logic [SIDE_W-1:0]  c_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c_rad_reg  <= {2'b00, b_sqx_reg} + {2'b00, b_sqy_reg} + {2'b00, b_sqz_reg};
        c_side_reg <= {b_neg_reg, b_above_reg, b_below_reg, b_cur_reg};
    end

    // Square root chain, one cell per root bit, most significant first.
    logic               valid_chain [0:RT_BITS];
    logic [SQ_BITS-1:0] rad_chain   [0:RT_BITS];
    logic [REM_W-1:0]   rem_chain   [0:RT_BITS];
    logic [RT_BITS-1:0] root_chain  [0:RT_BITS];
    logic [SIDE_W-1:0]  side_chain  [0:RT_BITS];

    assign valid_chain[0] = c_valid_reg;
    assign rad_chain[0]   = c_rad_reg;
    assign rem_chain[0]   = '0;
    assign root_chain[0]  = '0;
    assign side_chain[0]  = c_side_reg;

    for (genvar i = 0; i < RT_BITS; i++)
    begin : g_cell
        dlps_sqrt_cell #(
            .RT_BITS (RT_BITS),
            .SIDE_W  (SIDE_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_chain[i]),
            .in_rad    (rad_chain[i]),
            .in_rem    (rem_chain[i]),
            .in_root   (root_chain[i]),
            .in_side   (side_chain[i]),
            .out_valid (valid_chain[i+1]),
            .out_rad   (rad_chain[i+1]),
            .out_rem   (rem_chain[i+1]),
            .out_root  (root_chain[i+1]),
            .out_side  (side_chain[i+1])
        );
    end

    // Stage D: distance times gain.
    logic              d_valid_reg;
    logic [PROD_W-1:0] d_prod_reg;
    logic [SIDE_W-1:0] d_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else
        begin
            d_valid_reg <= valid_chain[RT_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        d_prod_reg <= PROD_W'(root_chain[RT_BITS]) * PROD_W'(step_gain_reg);
        d_side_reg <= side_chain[RT_BITS];
    end

    // Output stage: signed step, branch limit and saturation to the field.
    logic                    d_neg, d_above, d_below;
    logic [C-1:0]            d_cur;
    logic [MAG_W-1:0]        mag;
    logic signed [SUM_W-1:0] mag_x, step_x, cur_x, sum_x, hmax_x, hmin_x, res_x;
    logic signed [SUM_W-1:0] top_x, bottom_x;
    logic [C-1:0]            target_next;

    always_comb
    begin
        d_neg    = d_side_reg[SIDE_W-1];
        d_above  = d_side_reg[SIDE_W-2];
        d_below  = d_side_reg[SIDE_W-3];
        d_cur    = d_side_reg[C-1:0];
        mag      = d_prod_reg[PROD_W-1:GAIN_FRAC];
        mag_x    = $signed({{(SUM_W-MAG_W){1'b0}}, mag});
        step_x   = d_neg ? -mag_x : mag_x;
        cur_x    = $signed({{(SUM_W-C){d_cur[C-1]}}, d_cur});
        hmax_x   = $signed({{(SUM_W-C){height_max_reg[C-1]}}, height_max_reg});
        hmin_x   = $signed({{(SUM_W-C){height_min_reg[C-1]}}, height_min_reg});
        top_x    = $signed({{(SUM_W-C+1){1'b0}}, {(C-1){1'b1}}});
        bottom_x = $signed({{(SUM_W-C+1){1'b1}}, {(C-1){1'b0}}});
        sum_x    = cur_x + step_x;
        if (d_above)
        begin
            res_x = (sum_x < hmax_x) ? sum_x : hmax_x;
        end
        else if (d_below)
        begin
            res_x = (sum_x > hmin_x) ? sum_x : hmin_x;
        end
        else
        begin
            res_x = cur_x;
        end
        if (res_x > top_x)
        begin
            target_next = top_x[C-1:0];
        end
        else if (res_x < bottom_x)
        begin
            target_next = bottom_x[C-1:0];
        end
        else
        begin
            target_next = res_x[C-1:0];
        end
    end

    logic         done_reg;
    logic [C-1:0] target_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg <= target_next;
    end

    assign done          = done_reg;
    assign target_height = target_reg;

    // Every result traces back to an item taken a fixed number of cycles earlier.
    `DLPS_ASSERT_NOW(a_done_latency, clk, rst_n, done, $past(start, LAT))
    // Above the band the result never exceeds the upper limit.
    `DLPS_ASSERT_NEXT(a_cap_max, clk, rst_n, d_valid_reg && d_above, $signed(target_height) <= $signed($past(height_max_reg)))
    // Below the band the result never falls under the lower limit.
    `DLPS_ASSERT_NEXT(a_floor_min, clk, rst_n, d_valid_reg && !d_above && d_below, $signed(target_height) >= $signed($past(height_min_reg)))

endmodule

FILE: tb/tb_deflection_driven_lift_position_step.sv
// Self-checking testbench for the deflection driven lift position step block.
`timescale 1ns / 100ps

module tb_deflection_driven_lift_position_step;
    import dlps_pkg::*;

    localparam int CB = COORD_BITS_DEFAULT;
    localparam int LATENCY = CB + 5;
    localparam longint COORD_MAX = (longint'(1) << (CB - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;
    localparam logic [CB-1:0] C_MAX = {1'b0, {(CB - 1){1'b1}}};
    localparam logic [CB-1:0] C_MIN = {1'b1, {(CB - 1){1'b0}}};
    // Index past the last register; writes to it must be ignored.
    localparam logic [CFG_ADDR_BITS-1:0] REG_UNUSED = 3'd7;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [CB-1:0]            wrist_x;
    logic [CB-1:0]            wrist_y;
    logic [CB-1:0]            wrist_z;
    logic [CB-1:0]            current_height;
    logic                     done;
    logic [CB-1:0]            target_height;
    logic                     cfg_we;
    logic [CFG_ADDR_BITS-1:0] cfg_addr;
    logic [CB-1:0]            cfg_wdata;

    // Shadow copy of the configuration registers.
    logic [CB-1:0] cfg_rest_x;
    logic [CB-1:0] cfg_rest_y;
    logic [CB-1:0] cfg_rest_z;
    logic [15:0]   cfg_gain;
    logic [15:0]   cfg_frac;
    logic [CB-1:0] cfg_height_max;
    logic [CB-1:0] cfg_height_min;

    logic [CB-1:0] expected_heights[$];
    int            mismatch_count = 0;
    bit            idle_enable = 1'b1;

    deflection_driven_lift_position_step #(
        .COORD_BITS(CB)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .wrist_x(wrist_x),
        .wrist_y(wrist_y),
        .wrist_z(wrist_z),
        .current_height(current_height),
        .done(done),
        .target_height(target_height),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Saturate a wide value into the coordinate range.
    function automatic logic [CB-1:0] clamp_coord(input longint v);
        if (v > COORD_MAX)
            v = COORD_MAX;
        if (v < COORD_MIN)
            v = COORD_MIN;
        return v[CB-1:0];
    endfunction

    // Expected commanded height for one item under the shadow configuration.
    function automatic logic [CB-1:0] predict_target_height(input logic [CB-1:0] wx_v,
        input logic [CB-1:0] wy_v, input logic [CB-1:0] wz_v, input logic [CB-1:0] cur_v);
        longint        wx, wy, wz, cur, rx, ry, rz, hmax, hmin, frac;
        longint        dx, dy, dz, step, total, res;
        logic [63:0]   sq, root, trial, mag;
        wx = longint'($signed(wx_v));
        wy = longint'($signed(wy_v));
        wz = longint'($signed(wz_v));
        cur = longint'($signed(cur_v));
        rx = longint'($signed(cfg_rest_x));
        ry = longint'($signed(cfg_rest_y));
        rz = longint'($signed(cfg_rest_z));
        hmax = longint'($signed(cfg_height_max));
        hmin = longint'($signed(cfg_height_min));
        frac = longint'(cfg_frac);

        // Exact squared distance, then the floor of its square root.
        dx = wx - rx;
        dy = wy - ry;
        dz = wz - rz;
        if (dx < 0)
            dx = -dx;
        if (dy < 0)
            dy = -dy;
        if (dz < 0)
            dz = -dz;
        sq = dx * dx + dy * dy + dz * dz;
        root = '0;
        for (int b = CB + 3; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= sq)
                root = trial;
        end

        // Q8.8 gain, sign taken from the side of rest x.
        mag = (root * 64'(cfg_gain)) >> 8;
        step = (wx < rx) ? -longint'(mag) : longint'(mag);
        total = cur + step;

        // Band tests, the upper one first.
        if (wx * 65536 > rx * (65536 + frac))
            res = (total < hmax) ? total : hmax;
        else if (wx * 65536 < rx * (65536 - frac))
            res = (total > hmin) ? total : hmin;
        else
            res = cur;
        return clamp_coord(res);
    endfunction

    // Register defaults after reset.
    task automatic reset_registers();
        cfg_rest_x = '0;
        cfg_rest_y = '0;
        cfg_rest_z = '0;
        cfg_gain = STEP_GAIN_RESET;
        cfg_frac = DEADBAND_FRACTION_RESET;
        cfg_height_max = HEIGHT_MAX_RESET[CB-1:0];
        cfg_height_min = '0;
    endtask

    // Write one register; cfg_we is left high for back to back writes.
    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx, input logic [CB-1:0] data);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            REG_REST_X:            cfg_rest_x = data;
            REG_REST_Y:            cfg_rest_y = data;
            REG_REST_Z:            cfg_rest_z = data;
            REG_STEP_GAIN:         cfg_gain = data[15:0];
            REG_DEADBAND_FRACTION: cfg_frac = data[15:0];
            REG_HEIGHT_MAX:        cfg_height_max = data;
            REG_HEIGHT_MIN:        cfg_height_min = data;
            default: ;
        endcase
    endtask

    // Write every register, plus one write to an unused index.
    task automatic set_config(input logic [CB-1:0] rx, input logic [CB-1:0] ry,
        input logic [CB-1:0] rz, input logic [CB-1:0] gain, input logic [CB-1:0] frac,
        input logic [CB-1:0] hmax, input logic [CB-1:0] hmin);
        write_reg(REG_REST_X, rx);
        write_reg(REG_REST_Y, ry);
        write_reg(REG_REST_Z, rz);
        write_reg(REG_STEP_GAIN, gain);
        write_reg(REG_DEADBAND_FRACTION, frac);
        write_reg(REG_HEIGHT_MAX, hmax);
        write_reg(REG_HEIGHT_MIN, hmin);
        write_reg(REG_UNUSED, CB'($urandom));
        cfg_we <= 1'b0;
    endtask

    // Present one item and hold it until the block takes it.
    task automatic send_item(input logic [CB-1:0] x, input logic [CB-1:0] y,
        input logic [CB-1:0] z, input logic [CB-1:0] cur);
        logic ready;
        start <= 1'b1;
        wrist_x <= x;
        wrist_y <= y;
        wrist_z <= z;
        current_height <= cur;
        forever
        begin
            @(negedge clk);
            ready = !busy;
            @(posedge clk);
            if (ready)
                break;
        end
        expected_heights = {expected_heights, predict_target_height(x, y, z, cur)};
    endtask

    // Random gap on the input side, with junk on the payload.
    task automatic maybe_idle();
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            wrist_x <= CB'($urandom);
            wrist_y <= CB'($urandom);
            wrist_z <= CB'($urandom);
            current_height <= CB'($urandom);
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // Stop sending and wait for every outstanding result.
    task automatic wait_idle();
        start <= 1'b0;
        while (expected_heights.size() != 0)
            @(posedge clk);
    endtask

    // Check each result against the oldest expectation.
    always @(negedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (expected_heights.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0d", $time,
                    $signed(target_height));
                mismatch_count++;
            end
            else if (target_height !== expected_heights[0])
            begin
                $display("%0t: target_height mismatch, expected %0d, actual %0d", $time,
                    $signed(expected_heights[0]), $signed(target_height));
                mismatch_count++;
                void'(expected_heights.pop_front());
            end
            else
                void'(expected_heights.pop_front());
        end
    end

    // Coordinate drawn from the full range, a small window or the extremes.
    function automatic logic [CB-1:0] pick_coord();
        logic [CB-1:0] v;
        case ($urandom_range(0, 3))
            0: v = CB'($urandom);
            1: v = clamp_coord(longint'($urandom_range(0, 4000)) - 2000);
            2:
            begin
                case ($urandom_range(0, 3))
                    0: v = C_MAX;
                    1: v = C_MIN;
                    2: v = '0;
                    default: v = '1;
                endcase
            end
            default: v = CB'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [CB-1:0] near_value(input longint base, input int span);
        return clamp_coord(base + longint'($urandom_range(0, 2 * span)) - span);
    endfunction

    // Random item aimed at the band edges, the rest point and the limits.
    task automatic send_random_item();
        longint        rx, frac, upper, lower;
        logic [CB-1:0] x, y, z, cur;
        rx = longint'($signed(cfg_rest_x));
        frac = longint'(cfg_frac);
        upper = (rx * (65536 + frac)) >>> 16;
        lower = (rx * (65536 - frac)) >>> 16;
        case ($urandom_range(0, 5))
            0: x = near_value(upper, 2);
            1: x = near_value(lower, 2);
            2: x = near_value(rx, 3000);
            3: x = pick_coord();
            default: x = CB'($urandom);
        endcase
        y = $urandom_range(0, 1) ? near_value(longint'($signed(cfg_rest_y)), 5000) : pick_coord();
        z = $urandom_range(0, 1) ? near_value(longint'($signed(cfg_rest_z)), 5000) : pick_coord();
        case ($urandom_range(0, 3))
            0: cur = near_value(longint'($signed(cfg_height_max)), 3000);
            1: cur = near_value(longint'($signed(cfg_height_min)), 3000);
            2: cur = pick_coord();
            default: cur = CB'($urandom);
        endcase
        send_item(x, y, z, cur);
    endtask

    // Random configuration, extremes included; 16 bit registers get junk above bit 15.
    task automatic randomize_config();
        logic [CB-1:0] gain, frac, hmax, hmin, tmp;
        gain = CB'($urandom);
        frac = CB'($urandom);
        case ($urandom_range(0, 5))
            0: gain[15:0] = 16'd0;
            1: gain[15:0] = 16'd1;
            2: gain[15:0] = 16'd256;
            3: gain[15:0] = 16'hFFFF;
            default: ;
        endcase
        case ($urandom_range(0, 5))
            0: frac[15:0] = 16'd0;
            1: frac[15:0] = 16'd1;
            2: frac[15:0] = 16'h8000;
            3: frac[15:0] = 16'hFFFF;
            default: ;
        endcase
        hmax = pick_coord();
        hmin = pick_coord();
        // Mostly ordered limits, sometimes inverted.
        if ($urandom_range(0, 4) != 0 && $signed(hmax) < $signed(hmin))
        begin
            tmp = hmax;
            hmax = hmin;
            hmin = tmp;
        end
        set_config(pick_coord(), pick_coord(), pick_coord(), gain, frac, hmax, hmin);
    endtask

    // Items under the reset values of the registers.
    task automatic test_reset_defaults();
        send_item('0, '0, '0, clamp_coord(100));
        maybe_idle();
        send_item(clamp_coord(1000), '0, '0, '0);
        maybe_idle();
        send_item(clamp_coord(-1000), '0, '0, '0);
        maybe_idle();
        send_item(clamp_coord(600000), '0, '0, '0);
    endtask

    // Largest gain, no band, widest limits, coordinates at their extremes.
    task automatic test_field_extremes();
        wait_idle();
        set_config('0, '0, '0, 24'h00FFFF, '0, C_MAX, C_MIN);
        send_item(C_MAX, C_MAX, C_MAX, '0);
        maybe_idle();
        send_item(C_MIN, C_MIN, C_MIN, '0);
        maybe_idle();
        send_item('0, '0, '0, C_MAX);
        maybe_idle();
        send_item(clamp_coord(1), '1, clamp_coord(1), C_MIN);
    endtask

    // Negative rest x: swapped band, a step against the branch, saturation at the bottom.
    task automatic test_negative_rest_x();
        wait_idle();
        set_config(clamp_coord(-1000), C_MAX, C_MAX, 24'h00FFFF, 24'h008000, C_MAX, C_MIN);
        send_item(clamp_coord(-1200), C_MIN, C_MIN, C_MIN);
        maybe_idle();
        send_item(clamp_coord(-1500), '0, '0, '0);
        maybe_idle();
        send_item(clamp_coord(-1499), '0, '0, '0);
        maybe_idle();
        send_item('0, C_MAX, C_MAX, clamp_coord(5));
        maybe_idle();
        send_item(C_MIN, '0, '0, '0);
    endtask

    // Inverted limits, zero gain, and x one step either side of each band edge.
    task automatic test_inverted_limits();
        wait_idle();
        set_config(clamp_coord(100000), '0, '0, '0, clamp_coord(3277),
            clamp_coord(-5000), clamp_coord(5000));
        send_item(clamp_coord(105000), '0, '0, clamp_coord(12345));
        maybe_idle();
        send_item(clamp_coord(105001), '0, '0, clamp_coord(12345));
        maybe_idle();
        send_item(clamp_coord(94999), '0, '0, clamp_coord(-7777));
        maybe_idle();
        send_item(clamp_coord(95000), '0, '0, clamp_coord(-7777));
    endtask

    // Random configurations, each followed by a stream of random items.
    task automatic test_random_traffic();
        for (int phase = 0; phase < 12; phase++)
        begin
            wait_idle();
            randomize_config();
            // No input gaps in the last phases.
            idle_enable = (phase < 10) && ($urandom_range(0, 3) != 0);
            repeat (162)
            begin
                send_random_item();
                maybe_idle();
            end
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        wrist_x <= '0;
        wrist_y <= '0;
        wrist_z <= '0;
        current_height <= '0;
        cfg_we <= 1'b0;
        cfg_addr <= '0;
        cfg_wdata <= '0;
        reset_registers();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_field_extremes();
        test_negative_rest_x();
        test_inverted_limits();
        test_random_traffic();

        // Drain, then allow for any stray result.
        wait_idle();
        repeat (LATENCY + 5) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
